@@ rtl/assert_macros.svh @@
// Assertion macros used by the cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/f32cm_pkg.sv @@
// Constants, codes and round functions of the 32-bit Feistel cipher block.
`default_nettype none

package f32cm_pkg;

  typedef enum logic [1:0] {
    MODE_RAW = 2'd0,
    MODE_ECB = 2'd1,
    MODE_CBC = 2'd2,
    MODE_CTR = 2'd3
  } cipher_mode_e;

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECRYPT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LOW  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IV       = 3'd4;

  localparam int unsigned CFG_W  = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned ROT_L  = 3;
  localparam int unsigned MAX_ROUNDS = 8;

  // "abcd" packed little endian
  localparam logic [WORD_W-1:0] IV_RESET = 32'h6463_6261;

  typedef logic [HALF_W-1:0] half_t;
  typedef logic [WORD_W-1:0] word_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'd3;
      4'h1: y = 4'd5;
      4'h2: y = 4'd4;
      4'h3: y = 4'd8;
      4'h4: y = 4'd9;
      4'h5: y = 4'd1;
      4'h6: y = 4'd11;
      4'h7: y = 4'd13;
      4'h8: y = 4'd12;
      4'h9: y = 4'd0;
      4'hA: y = 4'd15;
      4'hB: y = 4'd2;
      4'hC: y = 4'd7;
      4'hD: y = 4'd6;
      4'hE: y = 4'd10;
      4'hF: y = 4'd14;
      default: y = 4'd0;
    endcase
    return y;
  endfunction

  // S-box every nibble, mix in the key, rotate left
  function automatic half_t round_fn(input half_t x, input half_t k);
    half_t s;
    s = {sbox4(x[15:12]), sbox4(x[11:8]), sbox4(x[7:4]), sbox4(x[3:0])} ^ k;
    return (s << ROT_L) | (s >> (HALF_W - ROT_L));
  endfunction

endpackage

`default_nettype wire

@@ rtl/feistel32_cipher_modes.sv @@
// Top level: streaming 32-bit Feistel block cipher with raw, ECB, CBC and CTR modes.
`default_nettype none
`include "assert_macros.svh"

// Each 32-bit word on the slave stream (tuser = restart) is handled in the
// configured mode and leaves on the master stream; raw mode passes it
// unchanged, the others use a ROUNDS-round Feistel network on 16-bit halves,
// high half on the left. Throughput is one word per clock while the master
// stream is ready. A request taken sits in the input register and passes to
// the result register when that is empty or being drained. All rounds and
// the mode logic sit between those two registers, and in CBC encryption the
// chain register closes its loop through the whole round network, so that
// path sets the clock period. Restart reloads the chain from the IV register
// before its word; writing the IV alone does not. There is no clearing pass
// after reset. Configuration must be written by the user only while idle;
// the block does not enforce it: index 0 mode, 1 decrypt, 2 key_low,
// 3 key_high, 4 initial_value; other indexes are dropped.
module feistel32_cipher_modes #(
  parameter int unsigned ROUNDS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [f32cm_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [f32cm_pkg::CFG_W-1:0]         cfg_data_i,
  // request stream in
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [f32cm_pkg::WORD_W-1:0]        s_axis_tdata,  // [31:0] data_word
  input  wire logic                                s_axis_tuser,  // [0] restart
  // result stream out
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [f32cm_pkg::WORD_W-1:0]             m_axis_tdata   // [31:0] result_word
);
  import f32cm_pkg::*;

  // configuration registers
  cipher_mode_e mode_q;
  logic         decrypt_q;
  logic [CFG_W-1:0] key_low_q, key_high_q;
  word_t        iv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ECB;
      decrypt_q  <= 1'b0;
      key_low_q  <= '0;
      key_high_q <= '0;
      iv_q       <= IV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:     mode_q     <= cipher_mode_e'(cfg_data_i[1:0]);
        REG_DECRYPT:  decrypt_q  <= cfg_data_i[0];
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_IV:       iv_q       <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: input register -> result register
  logic  in_valid_q, out_valid_q;
  word_t in_data_q;
  logic  in_restart_q;
  word_t out_data_q;
  logic  advance;

  // result register may load when empty or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  // chain / counter selection and cipher input
  word_t chain_q, chain_d, chain_cur;
  word_t cipher_in, cipher_out, result_d;
  logic  inverse;

  assign chain_cur = in_restart_q ? iv_q : chain_q;
  assign inverse   = decrypt_q && (mode_q != MODE_CTR);

  always_comb begin
    case (mode_q)
      MODE_CBC: cipher_in = decrypt_q ? in_data_q : (in_data_q ^ chain_cur);
      MODE_CTR: cipher_in = chain_cur;
      default:  cipher_in = in_data_q;
    endcase
  end

  // Feistel network, one generate step per round
  logic [2*CFG_W-1:0] key_all;
  half_t left_w  [ROUNDS+1];
  half_t right_w [ROUNDS+1];

  assign key_all    = {key_high_q, key_low_q};
  assign left_w[0]  = cipher_in[WORD_W-1:HALF_W];
  assign right_w[0] = cipher_in[HALF_W-1:0];

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    localparam int unsigned FwdIdx = g % MAX_ROUNDS;
    localparam int unsigned RevIdx = (ROUNDS - 1 - g) % MAX_ROUNDS;
    half_t rk;
    assign rk = inverse ? key_all[RevIdx*HALF_W +: HALF_W]
                        : key_all[FwdIdx*HALF_W +: HALF_W];
    assign left_w[g+1]  = right_w[g] ^ round_fn(left_w[g], rk);
    assign right_w[g+1] = left_w[g];
  end

  // final swap
  assign cipher_out = {right_w[ROUNDS], left_w[ROUNDS]};

  always_comb begin
    result_d = in_data_q;
    chain_d  = chain_cur;
    case (mode_q)
      MODE_ECB: result_d = cipher_out;
      MODE_CBC: begin
        if (decrypt_q) begin
          result_d = cipher_out ^ chain_cur;
          chain_d  = in_data_q;
        end else begin
          result_d = cipher_out;
          chain_d  = cipher_out;
        end
      end
      MODE_CTR: begin
        result_d = in_data_q ^ cipher_out;
        chain_d  = chain_cur + 32'd1;
      end
      default: ;
    endcase
  end

  // chain state moves only as a word passes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= IV_RESET;
    end else if (advance && in_valid_q) begin
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_data_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  `ASSERT_NEXT(a_chain_hold, clk_i, rst_ni, !(advance && in_valid_q), $stable(chain_q))
  `ASSERT_NEXT(a_ctr_count, clk_i, rst_ni,
    advance && in_valid_q && mode_q == MODE_CTR && !in_restart_q,
    chain_q == WORD_W'($past(chain_q) + 32'd1))
  `ASSERT_NEXT(a_raw_pass, clk_i, rst_ni, advance && in_valid_q && mode_q == MODE_RAW,
    m_axis_tdata == $past(in_data_q))
  `ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, !s_axis_tready, in_valid_q && out_valid_q)

endmodule

`default_nettype wire

@@ tb/sv/feistel32_cipher_modes_test.sv @@
// Self-checking testbench for the streaming Feistel cipher with raw, ECB, CBC and CTR modes.
`timescale 1ns / 1ps

module feistel32_cipher_modes_test;
  import f32cm_pkg::*;

  // Rounds of the instance; the predictor runs the same count.
  localparam int unsigned ROUNDS_TB = 8;
  // Indexes past the register list; the block must drop these writes.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  // Nibble substitution, entry n in bits 4n+3:4n.
  localparam logic [63:0] NIB_SUB = 64'hEA67_2F0C_DB19_8453;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_WORDS = 950;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [WORD_W-1:0]    s_axis_tdata;  // [31:0] data_word
  logic                 s_axis_tuser;  // [0] restart
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [WORD_W-1:0]    m_axis_tdata;  // [31:0] result_word

  feistel32_cipher_modes #(
    .ROUNDS(ROUNDS_TB)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // One row of the directed plan: either a register write or a request.
  // fixed marks rows whose result is typed in rather than predicted.
  typedef struct {
    bit                   is_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    word_t                data;
    bit                   restart;
    bit                   fixed;
    word_t                result;
  } plan_row_t;

  // Mirror of the block's registers and chain / counter word.
  cipher_mode_e mode_q;
  bit           decrypt_q;
  logic [63:0]  key_lo_q;
  logic [63:0]  key_hi_q;
  word_t        iv_q;
  word_t        chain_q;

  word_t       expected_words[$];
  plan_row_t   plan[$];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          idle_on;
  // Typed-in result travels beside the request it belongs to.
  bit          row_fixed;
  word_t       row_value;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic half_t round_key(int unsigned r);
    if (r < 4) begin
      return key_lo_q[16*r +: 16];
    end
    return key_hi_q[16*(r-4) +: 16];
  endfunction

  // substitute each nibble, key in, rotate left by three
  function automatic half_t mix_half(half_t x, half_t k);
    half_t s;
    for (int j = 0; j < 4; j++) begin
      s[4*j +: 4] = NIB_SUB[4*x[4*j +: 4] +: 4];
    end
    s = s ^ k;
    return {s[12:0], s[15:13]};
  endfunction

  function automatic word_t feistel_run(word_t w, bit inverse);
    half_t       lh;
    half_t       rh;
    half_t       f;
    int unsigned r;
    lh = w[31:16];
    rh = w[15:0];
    for (int unsigned i = 0; i < ROUNDS_TB; i++) begin
      r = inverse ? (ROUNDS_TB - 1 - i) : i;
      f = mix_half(lh, round_key(r));
      {lh, rh} = {rh ^ f, lh};
    end
    // halves swap on the way out
    return {rh, lh};
  endfunction

  // Result of one request; advances the chain / counter mirror.
  function automatic word_t cipher_step(word_t data, bit restart);
    word_t res;
    if (restart) begin
      chain_q = iv_q;
    end
    case (mode_q)
      MODE_ECB: begin
        res = feistel_run(data, decrypt_q);
      end
      MODE_CBC: begin
        if (decrypt_q) begin
          res = feistel_run(data, 1'b1) ^ chain_q;
          chain_q = data;
        end else begin
          res = feistel_run(data ^ chain_q, 1'b0);
          chain_q = res;
        end
      end
      MODE_CTR: begin
        // counter is always enciphered, decrypt flag is ignored
        res = data ^ feistel_run(chain_q, 1'b0);
        chain_q = chain_q + 32'd1;
      end
      default: begin
        res = data;
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: results first, then the request accepted at the same edge, so
  // the order of processes within a step never matters.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    word_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: result_word mismatch, expected %h actual %h",
                     $time, want, m_axis_tdata);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = cipher_step(s_axis_tdata, s_axis_tuser);
        if (row_fixed) begin
          want = row_value;
        end
        expected_words.push_back(want);
      end
    end
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stall bursts while idle_on, otherwise always ready.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Write enable stays high across back-to-back writes; the next request or
  // drain lowers it, so it never gets two assignments in one step.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      REG_MODE:     mode_q    = cipher_mode_e'(val[1:0]);
      REG_DECRYPT:  decrypt_q = val[0];
      REG_KEY_LOW:  key_lo_q  = val;
      REG_KEY_HIGH: key_hi_q  = val;
      REG_IV:       iv_q      = val[WORD_W-1:0];  // chain untouched until restart
      default: ;
    endcase
  endtask

  // Present one request and hold it until accepted; tvalid is left high.
  task automatic send_word(word_t data, bit restart, bit fixed, word_t result);
    cfg_we_i <= 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= restart;
    row_fixed     <= fixed;
    row_value     <= result;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every expected result is back.
  task automatic drain();
    cfg_we_i      <= 1'b0;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
    // two-stage pipe, let it settle before the next step
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic plan_row_t cfg_row(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    plan_row_t row;
    row = '{1'b1, idx, val, '0, 1'b0, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t word_row(word_t data, bit restart, bit fixed, word_t result);
    plan_row_t row;
    row = '{1'b0, '0, '0, data, restart, fixed, result};
    return row;
  endfunction

  // Random register settings for one phase; mode every time, the rest often.
  task automatic random_config();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       v[1:0] = MODE_RAW;
      1:       v[1:0] = MODE_ECB;
      2, 3:    v[1:0] = MODE_CBC;
      default: v[1:0] = MODE_CTR;
    endcase
    write_reg(REG_MODE, v);
    if ($urandom_range(0, 1)) write_reg(REG_DECRYPT, {$urandom, $urandom});
    if ($urandom_range(0, 1)) write_reg(REG_KEY_LOW, pick64());
    if ($urandom_range(0, 1)) write_reg(REG_KEY_HIGH, pick64());
    if ($urandom_range(0, 2) == 0) write_reg(REG_IV, pick64());
    if ($urandom_range(0, 7) == 0) write_reg(REG_IDX_W'($urandom_range(5, 7)), pick64());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int unsigned sent;
    int unsigned phase;
    int unsigned len;
    bit          prev_word;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    row_fixed     <= 1'b0;
    row_value     <= '0;
    idle_on       = 1'b1;
    err_count     = 0;
    cycle_count   = 0;
    // reset state of the registers and the chain
    mode_q    = MODE_ECB;
    decrypt_q = 1'b0;
    key_lo_q  = '0;
    key_hi_q  = '0;
    iv_q      = IV_RESET;
    chain_q   = IV_RESET;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan. Raw-mode rows carry the typed-in result.
    plan.push_back(word_row(32'h0000_0000, 1'b0, 1'b0, '0));  // ECB, zero key, after reset
    plan.push_back(word_row(32'hFFFF_FFFF, 1'b1, 1'b0, '0));
    plan.push_back(cfg_row(REG_MODE, 64'(MODE_RAW)));
    plan.push_back(cfg_row(REG_IV, 64'h0));
    plan.push_back(word_row(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000));
    // restart in raw still reloads the chain from the new IV
    plan.push_back(word_row(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_MODE, 64'(MODE_CTR)));
    plan.push_back(word_row(32'h0000_0000, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_KEY_HIGH, 64'h0123_4567_89AB_CDEF));
    plan.push_back(word_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(REG_DECRYPT, 64'd1));  // CTR ignores it
    plan.push_back(word_row(32'h1234_5678, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(REG_MODE, 64'(MODE_CBC)));
    plan.push_back(word_row(32'hA5A5_A5A5, 1'b1, 1'b0, '0));
    plan.push_back(word_row(32'h5A5A_5A5A, 1'b0, 1'b0, '0));
    // IV write alone must leave the chain where it is
    plan.push_back(cfg_row(REG_IV, 64'hFFFF_FFFF));
    plan.push_back(word_row(32'h0000_0000, 1'b0, 1'b0, '0));
    plan.push_back(word_row(32'hFFFF_FFFF, 1'b1, 1'b0, '0));
    plan.push_back(cfg_row(REG_DECRYPT, 64'd0));
    plan.push_back(word_row(32'h0000_0000, 1'b1, 1'b0, '0));
    plan.push_back(word_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0));
    plan.push_back(word_row(32'h1357_9BDF, 1'b0, 1'b0, '0));
    // writes past the register list are dropped
    plan.push_back(cfg_row(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_SPARE_HI, 64'h0));
    plan.push_back(word_row(32'h0000_0000, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(REG_MODE, 64'(MODE_ECB)));
    plan.push_back(cfg_row(REG_DECRYPT, 64'd1));
    plan.push_back(word_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0));
    plan.push_back(word_row(32'h0000_0000, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(REG_KEY_LOW, 64'h0));
    plan.push_back(cfg_row(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(word_row(32'h8000_0001, 1'b0, 1'b0, '0));
    plan.push_back(cfg_row(REG_MODE, 64'(MODE_RAW)));
    plan.push_back(word_row(32'h7FFF_FFFE, 1'b1, 1'b1, 32'h7FFF_FFFE));

    prev_word = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        // registers only change with the pipe empty
        if (prev_word) drain();
        write_reg(plan[i].idx, plan[i].val);
        prev_word = 1'b0;
      end else begin
        send_word(plan[i].data, plan[i].restart, plan[i].fixed, plan[i].result);
        prev_word = 1'b1;
      end
    end

    // Random phases: fresh settings, then a stream of requests.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      drain();
      random_config();
      len = $urandom_range(40, 100);
      if (len > RANDOM_WORDS - sent) len = RANDOM_WORDS - sent;
      // last stretch runs flat out; some earlier phases too
      idle_on = (sent < RANDOM_WORDS - 100) && ($urandom_range(0, 3) != 0);
      for (int unsigned k = 0; k < len; k++) begin
        // final hundred requests go without idling
        if (sent + k >= RANDOM_WORDS - 100) idle_on = 1'b0;
        if (phase == 3 && k == len / 2) begin
          // sender holds off until every result is back
          drain();
        end
        send_word($urandom, (k == 0) ? 1'($urandom_range(0, 1))
                                     : ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
      sent += len;
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/f32cm_pkg.sv
rtl/feistel32_cipher_modes.sv
tb/sv/feistel32_cipher_modes_test.sv
